FILE: hw/rtl/mtoc_pkg.sv
// shared types, constants and helpers for the multi-term occurrence counter
package mtoc_pkg;

	localparam int MAX_TERMS    = 8;
	localparam int MAX_TERM_LEN = 32;
	localparam int COUNT_WIDTH  = 32;

	// field widths of the beats
	localparam int TERM_IDX_W = 3;
	localparam int POS_W      = 5;
	localparam int VALUE_W    = 8;
	localparam int OCC_W      = 32;
	localparam int TCNT_W     = 4;
	localparam int LEN_W      = 6;

	typedef logic [VALUE_W-1:0]     byte_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [LEN_W-1:0]       len_t;
	typedef logic [TCNT_W-1:0]      tcnt_t;

	typedef enum logic [1:0] {
		KIND_TERM_BYTE = 2'd0,
		KIND_TERM_LEN  = 2'd1,
		KIND_DOC_BYTE  = 2'd2,
		KIND_DOC_END   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [TERM_IDX_W-1:0] term_index;
		logic [POS_W-1:0]      position;
		logic [VALUE_W-1:0]    value;
	} in_item_t;

	typedef struct packed {
		logic [TERM_IDX_W-1:0] term_id;
		logic [OCC_W-1:0]      occurrences;
		logic                  last;
	} out_item_t;

	// term store write controls
	typedef struct packed {
		logic                  byte_we;
		logic                  len_we;
		logic [TERM_IDX_W-1:0] idx;
		logic [POS_W-1:0]      pos;
		logic [VALUE_W-1:0]    value;
	} term_wr_t;

	localparam len_t  LEN_MAX   = len_t'(MAX_TERM_LEN);
	localparam tcnt_t TERMS_MAX = tcnt_t'(MAX_TERMS);

	// saturating increment of a match count
	function automatic count_t sat_inc(input count_t c);
		return (&c) ? c : c + count_t'(1);
	endfunction

endpackage

FILE: hw/rtl/mtoc_terms.sv
// term byte and length store with the parallel window comparators
module mtoc_terms import mtoc_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  term_wr_t                          wr,
	input  logic [MAX_TERM_LEN-1:0][VALUE_W-1:0] window,
	input  len_t                              seen,
	output logic [MAX_TERMS-1:0]              hit,
	output logic [MAX_TERMS-1:0]              empty
);

	byte_t tb_q  [MAX_TERMS][MAX_TERM_LEN];
	len_t  len_q [MAX_TERMS];

	// term bytes, no reset
	always_ff @(posedge clk) begin
		if (wr.byte_we) begin
			tb_q[wr.idx][wr.pos] <= wr.value;
		end
	end

	// term lengths, clamped to the window size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < MAX_TERMS; t++) begin
				len_q[t] <= '0;
			end
		end else if (wr.len_we) begin
			if (wr.value > VALUE_W'(MAX_TERM_LEN)) begin
				len_q[wr.idx] <= LEN_MAX;
			end else begin
				len_q[wr.idx] <= wr.value[LEN_W-1:0];
			end
		end
	end

	// term byte j lines up with the window byte len-1-j back from the newest
	always_comb begin
		logic ok;
		len_t sel;
		hit   = '0;
		empty = '0;
		for (int t = 0; t < MAX_TERMS; t++) begin
			ok = 1'b1;
			for (int j = 0; j < MAX_TERM_LEN; j++) begin
				sel = len_q[t] - len_t'(j) - len_t'(1);
				if ((len_t'(j) < len_q[t]) && (tb_q[t][j] != window[sel[POS_W-1:0]])) begin
					ok = 1'b0;
				end
			end
			hit[t]   = ok && (len_q[t] <= seen);
			empty[t] = (len_q[t] == '0);
		end
	end

endmodule

FILE: hw/rtl/multi_term_occurrence_counter.sv
// top level of the multi-term occurrence counter
//
// Counts overlapping occurrences of up to eight search terms in a byte stream.
// Input channel (in_valid/in_ready/in_data) carries setup beats (term byte,
// term length), document bytes and an end-of-document beat. Output channel
// (out_valid/out_ready/out_data) carries one count per active term after each
// end of document, term 0 first, the final one with last set.
// cfg_we/cfg_data writes term_count, the number of terms reported.
// Setup and document beats are never held back: each is handled in a single
// compare-and-count stage, where all term windows are compared in parallel,
// while the next beat is taken; only an end-of-document beat can wait.
// An end-of-document beat snapshots the counts into a result buffer and clears
// counts and window; the results leave from that buffer through the output
// register, one result per cycle while out_ready stays high.
// A second end-of-document beat waits in the input stage, holding back the
// beats behind it, until the previous results are all drained; document bytes
// ahead of it keep flowing meanwhile.
// When the receiver stalls, the output register holds its beat.
// Reset clears term lengths, window, counts, term_count and all valids;
// term bytes hold unknown data until written.
module multi_term_occurrence_counter import mtoc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  in_item_t      in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output out_item_t     out_data,
	input  logic          cfg_we,
	input  tcnt_t         cfg_data
);

	in_item_t in_s1;
	logic     in_valid_s1;

	tcnt_t term_count_q;
	logic [MAX_TERM_LEN-1:0][VALUE_W-1:0] window_q;
	logic [MAX_TERM_LEN-1:0][VALUE_W-1:0] win_nxt;
	len_t   seen_q;
	len_t   seen_nxt;
	count_t cnt_q [MAX_TERMS];
	count_t buf_q [MAX_TERMS];
	tcnt_t  emit_idx_q;
	tcnt_t  emit_cnt_q;
	tcnt_t  active;
	out_item_t out_q;
	logic   out_valid_q;

	logic busy;
	logic s1_go;
	logic doc;
	logic eod;
	logic load;
	term_wr_t wr;
	logic [MAX_TERMS-1:0] hit;
	logic [MAX_TERMS-1:0] empty;

	// input stage handshake
	assign busy     = emit_idx_q < emit_cnt_q;
	assign s1_go    = in_valid_s1 && !((in_s1.kind == KIND_DOC_END) && busy);
	assign in_ready = !in_valid_s1 || s1_go;
	assign doc      = s1_go && (in_s1.kind == KIND_DOC_BYTE);
	assign eod      = s1_go && (in_s1.kind == KIND_DOC_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= '0;
		end else if (cfg_we) begin
			term_count_q <= cfg_data;
		end
	end

	// term store writes
	always_comb begin
		wr.byte_we = s1_go && (in_s1.kind == KIND_TERM_BYTE);
		wr.len_we  = s1_go && (in_s1.kind == KIND_TERM_LEN);
		wr.idx     = in_s1.term_index;
		wr.pos     = in_s1.position;
		wr.value   = in_s1.value;
	end

	// window as it stands after the current byte
	assign win_nxt  = {window_q[MAX_TERM_LEN-2:0], in_s1.value};
	assign seen_nxt = (seen_q == LEN_MAX) ? seen_q : seen_q + len_t'(1);

	mtoc_terms u_terms (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.window (win_nxt),
		.seen   (seen_nxt),
		.hit    (hit),
		.empty  (empty)
	);

	// window and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
		end else if (eod) begin
			window_q <= '0;
			seen_q   <= '0;
		end else if (doc) begin
			window_q <= win_nxt;
			seen_q   <= seen_nxt;
		end
	end

	// match counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < MAX_TERMS; t++) begin
				cnt_q[t] <= '0;
			end
		end else begin
			for (int t = 0; t < MAX_TERMS; t++) begin
				if (eod) begin
					cnt_q[t] <= '0;
				end else if (doc && hit[t]) begin
					cnt_q[t] <= sat_inc(cnt_q[t]);
				end
			end
		end
	end

	// result snapshot, empty terms get the extra one
	always_ff @(posedge clk) begin
		if (eod) begin
			for (int t = 0; t < MAX_TERMS; t++) begin
				buf_q[t] <= empty[t] ? sat_inc(cnt_q[t]) : cnt_q[t];
			end
		end
	end

	// result walker
	assign active = (term_count_q > TERMS_MAX) ? TERMS_MAX : term_count_q;
	assign load   = busy && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
			emit_cnt_q <= '0;
		end else if (eod) begin
			emit_idx_q <= '0;
			emit_cnt_q <= active;
		end else if (load) begin
			emit_idx_q <= emit_idx_q + tcnt_t'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.term_id     <= emit_idx_q[TERM_IDX_W-1:0];
			out_q.occurrences <= OCC_W'(buf_q[emit_idx_q[TERM_IDX_W-1:0]]);
			out_q.last        <= ((emit_idx_q + tcnt_t'(1)) == emit_cnt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: hw/rtl/mtoc_checker.sv
// port-level checks for the multi-term occurrence counter, bound to the top level
module mtoc_checker import mtoc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data,
	input logic      cfg_we,
	input tcnt_t     cfg_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// results of one run follow each other without gaps, ids counting up
	a_run_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=>
		out_valid && (out_data.term_id == TERM_IDX_W'($past(out_data.term_id) + 1'b1)))
		else $error("run of results broken or out of order");

	// a new run starts at term zero
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last |=> !out_valid || (out_data.term_id == '0))
		else $error("run did not start at term zero");

	// setup and document beats never hold up the next beat
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.kind != KIND_DOC_END) |=> in_ready)
		else $error("input stalled after a non-final beat");

	// the term count is written with known data and no result beat pending
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !out_valid && !$isunknown(cfg_data))
		else $error("term count written while results were pending");

endmodule

bind multi_term_occurrence_counter mtoc_checker u_mtoc_checker (.*);
